// ----- hdl/crht_pkg.sv -----
`timescale 1ns / 1ps
// Shared package for the cache replacement hit tracker.
// Holds field widths, register indexes, policy codes and the cell control type.
// No dependencies.
package crht_pkg;

	localparam int BLOCKS_DEF = 16;
	localparam int KEY_W = 32;
	localparam int SLOT_W = 4;
	localparam int CNT_W = 32;
	localparam int BC_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [BC_W-1:0] BLOCK_COUNT_RST = BC_W'(16);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

	localparam logic POL_FIFO = 1'b0;
	localparam logic POL_LRU = 1'b1;

	typedef struct packed {
		logic load_new;
		logic shift;
	} cell_ctl_t;

endpackage

// ----- hdl/cache_replacement_hit_tracker_top.sv -----
`timescale 1ns / 1ps
// Top level of the cache replacement hit tracker: control, counters and the cell row.
// Depends on crht_pkg and crht_cell.
//
// Fully associative cache of up to BLOCKS entries with FIFO or LRU replacement.
// Each accepted request is registered, then looked up by a row of cells that
// all compare it at once; in the same cycle the cells are rewritten (LRU entries shift
// one cell toward slot 0) and the result is loaded into the output register. A result
// goes through the request register and then the output register, and one request per
// cycle is sustained as long as results are taken; the compare and update done together
// across the cell row set that rate. There is no clearing pass after reset. Write
// configuration only while idle.
module cache_replacement_hit_tracker_top #(
	parameter int BLOCKS = crht_pkg::BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [crht_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crht_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [crht_pkg::KEY_W-1:0]      ref_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [crht_pkg::SLOT_W-1:0]     slot,
	output logic [crht_pkg::CNT_W-1:0]      hit_total,
	output logic [crht_pkg::CNT_W-1:0]      refs_seen
);
	import crht_pkg::*;

	localparam int CW = $clog2(BLOCKS + 1);
	localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int XW = 8;

	logic             policy_q;
	logic [BC_W-1:0]  block_count_q;
	logic             busy_q;
	logic [KEY_W-1:0] ref_s1;
	logic             out_valid_q;
	logic             hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] ref_cnt_q;
	logic [CW-1:0]    occ_q;
	logic [IW-1:0]    ptr_q;

	logic             process;
	logic [KEY_W-1:0] entry_v [BLOCKS];
	logic [BLOCKS-1:0] cell_match;
	logic [BLOCKS-1:0] match_v;
	cell_ctl_t        ctl_v [BLOCKS];

	logic [XW-1:0] eff8, occ8, used8, pos8, last8, lo8, victim8, target8, slot8, ptr_next8;
	logic          hit_c, full_c, lru_op, wr_en, occ_inc, ptr_upd;

	assign process = busy_q && (!out_valid_q || out_ready);
	assign in_ready = !busy_q || process;

	always_comb begin
		logic [XW-1:0] bc8;
		bc8 = XW'(block_count_q);
		if (bc8 == '0) begin
			eff8 = XW'(1);
		end else if (bc8 > XW'(BLOCKS)) begin
			eff8 = XW'(BLOCKS);
		end else begin
			eff8 = bc8;
		end
		occ8 = XW'(occ_q);
		used8 = (occ8 < eff8) ? occ8 : eff8;
		full_c = (occ8 >= eff8);
		for (int i = 0; i < BLOCKS; i++) begin
			match_v[i] = cell_match[i] && (XW'(i) < used8);
		end
		hit_c = |match_v;
		pos8 = '0;
		for (int i = BLOCKS - 1; i >= 0; i--) begin
			if (match_v[i]) begin
				pos8 = XW'(i);
			end
		end
		last8 = used8 - XW'(1);
		lo8 = hit_c ? pos8 : '0;
		victim8 = (XW'(ptr_q) < eff8) ? XW'(ptr_q) : '0;
		ptr_next8 = ((victim8 + XW'(1)) == eff8) ? '0 : (victim8 + XW'(1));
		lru_op = 1'b0;
		wr_en = 1'b0;
		occ_inc = 1'b0;
		ptr_upd = 1'b0;
		target8 = '0;
		slot8 = '0;
		priority if (hit_c) begin
			if (policy_q == POL_LRU) begin
				lru_op = 1'b1;
				wr_en = 1'b1;
				target8 = last8;
				slot8 = last8;
			end else begin
				slot8 = pos8;
			end
		end else if (full_c) begin
			if (policy_q == POL_LRU) begin
				lru_op = 1'b1;
				wr_en = 1'b1;
				target8 = last8;
				slot8 = last8;
			end else begin
				wr_en = 1'b1;
				ptr_upd = 1'b1;
				target8 = victim8;
				slot8 = victim8;
			end
		end else begin
			wr_en = 1'b1;
			occ_inc = 1'b1;
			target8 = occ8;
			slot8 = occ8;
		end
	end

	for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
		logic [KEY_W-1:0] next_entry;
		if (g == BLOCKS - 1) begin : g_top
			assign next_entry = '0;
		end else begin : g_mid
			assign next_entry = entry_v[g+1];
		end
		assign ctl_v[g].load_new = process && wr_en && (XW'(g) == target8);
		assign ctl_v[g].shift = process && lru_op && (XW'(g) >= lo8) && (XW'(g) < last8);
		crht_cell u_cell (
			.clk       (clk),
			.ctl       (ctl_v[g]),
			.key       (ref_s1),
			.next_entry(next_entry),
			.entry     (entry_v[g]),
			.match     (cell_match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY:      policy_q <= cfg_data[0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ref_s1 <= ref_value;
		end
		if (process) begin
			hit_q <= hit_c;
			slot_q <= slot8[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			hit_cnt_q <= '0;
			ref_cnt_q <= '0;
			occ_q <= '0;
			ptr_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end else if (process) begin
				busy_q <= 1'b0;
			end
			if (process) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (process) begin
				if (hit_c && hit_cnt_q != CNT_MAX) begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end
				if (ref_cnt_q != CNT_MAX) begin
					ref_cnt_q <= ref_cnt_q + CNT_W'(1);
				end
				if (occ_inc) begin
					occ_q <= occ_q + CW'(1);
				end
				if (ptr_upd) begin
					ptr_q <= ptr_next8[IW-1:0];
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign slot = slot_q;
	assign hit_total = hit_cnt_q;
	assign refs_seen = ref_cnt_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(occ_q) <= XW'(BLOCKS))
		else $error("occupancy exceeds the number of cells");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		process && !hit_c && !full_c |=> occ_q == $past(occ_q) + CW'(1))
		else $error("a miss into a free slot did not advance occupancy");

	a_hits_le_refs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hit_cnt_q <= ref_cnt_q)
		else $error("hit total exceeds request total");

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !process |=> busy_q && $stable(ref_s1))
		else $error("pending request lost while the output was stalled");

endmodule

// ----- hdl/crht_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the cache row: holds one entry and compares it to the request.
// Depends on crht_pkg for the key width and the cell control type.
module crht_cell (
	input  logic                        clk,
	input  crht_pkg::cell_ctl_t         ctl,
	input  logic [crht_pkg::KEY_W-1:0]  key,
	input  logic [crht_pkg::KEY_W-1:0]  next_entry,
	output logic [crht_pkg::KEY_W-1:0]  entry,
	output logic                        match
);
	import crht_pkg::*;

	logic [KEY_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load_new) begin
			entry_q <= key;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == key);

endmodule
